// ===== rtl/mi3_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mi3_pkg
// Shared types and pipeline depths for the 3x3 matrix inverse.
// -----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ElemW  = 16;  // Q8.8 element
  localparam int ProdW  = 32;  // element product
  localparam int AdjW   = 33;  // adjugate entry, Q16.16
  localparam int TermW  = 49;  // element times adjugate entry
  localparam int DetW   = 51;  // determinant, Q24.24 with headroom
  localparam int QuoW   = 33;  // quotient bits kept below the overflow check
  localparam int ResW   = 32;  // Q16.16 result

  // lane latency: operand prep, one stage per quotient bit, saturation
  localparam int DivLat = QuoW + 2;
  // matrix front end: products, adjugate, det terms, det sum
  localparam int FrontLat = 4;
  localparam int TotLat   = FrontLat + DivLat;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [AdjW-1:0]  adj_t;
  typedef logic signed [DetW-1:0]  det_t;
  typedef logic signed [ResW-1:0]  res_t;

endpackage

// ===== rtl/mi3_adj.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mi3_adj
// Two stages: eighteen element products, then the nine adjugate entries.
// The first row is carried along for the determinant.
// -----------------------------------------------------------------------------
module mi3_adj
  import mi3_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  elem_t a_i   [9],
  output adj_t  adj_o [9],
  output elem_t row_o [3]
);

  logic signed [ProdW-1:0] p_r [18];
  elem_t row1_r [3];
  elem_t row2_r [3];
  adj_t  adj_r  [9];

  // form the cofactor products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= a_i[4] * a_i[8];
      p_r[1]  <= a_i[5] * a_i[7];
      p_r[2]  <= a_i[2] * a_i[7];
      p_r[3]  <= a_i[1] * a_i[8];
      p_r[4]  <= a_i[1] * a_i[5];
      p_r[5]  <= a_i[4] * a_i[2];
      p_r[6]  <= a_i[5] * a_i[6];
      p_r[7]  <= a_i[3] * a_i[8];
      p_r[8]  <= a_i[0] * a_i[8];
      p_r[9]  <= a_i[2] * a_i[6];
      p_r[10] <= a_i[2] * a_i[3];
      p_r[11] <= a_i[0] * a_i[5];
      p_r[12] <= a_i[3] * a_i[7];
      p_r[13] <= a_i[6] * a_i[4];
      p_r[14] <= a_i[1] * a_i[6];
      p_r[15] <= a_i[0] * a_i[7];
      p_r[16] <= a_i[0] * a_i[4];
      p_r[17] <= a_i[1] * a_i[3];
      row1_r  <= a_i[0:2];
    end
  end

  // take the differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        adj_r[k] <= AdjW'(p_r[2*k]) - AdjW'(p_r[2*k+1]);
      end
      row2_r <= row1_r;
    end
  end

  assign adj_o = adj_r;
  assign row_o = row2_r;

endmodule

// ===== rtl/mi3_det.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mi3_det
// Two stages: first-row expansion terms, then the determinant sum.
// The adjugate is delayed to stay aligned with the determinant.
// -----------------------------------------------------------------------------
module mi3_det
  import mi3_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  adj_t  adj_i [9],
  input  elem_t row_i [3],
  output adj_t  adj_o [9],
  output det_t  det_o
);

  logic signed [TermW-1:0] t_r [3];
  adj_t adj1_r [9];
  adj_t adj2_r [9];
  det_t det_r;

  // multiply the first row by its cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= TermW'(row_i[0]) * TermW'(adj_i[0]);
      t_r[1] <= TermW'(row_i[1]) * TermW'(adj_i[3]);
      t_r[2] <= TermW'(row_i[2]) * TermW'(adj_i[6]);
      adj1_r <= adj_i;
    end
  end

  // sum the terms
  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= DetW'(t_r[0]) + DetW'(t_r[1]) + DetW'(t_r[2]);
      adj2_r <= adj1_r;
    end
  end

  assign adj_o = adj2_r;
  assign det_o = det_r;

endmodule

// ===== rtl/mi3_div_lane.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider for one element: |adj| * 2^24 / |det|,
// one quotient bit per stage, then sign, saturation and zero forcing.
// -----------------------------------------------------------------------------
module mi3_div_lane
  import mi3_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  adj_t adj_i,
  input  det_t det_i,
  output res_t quot_o
);

  logic [AdjW-1:0] mag_adj;
  logic [DetW-1:0] mag_det;

  logic [DetW-1:0] rem_r  [QuoW+1];
  logic [QuoW-1:0] low_r  [QuoW+1];
  logic [QuoW-1:0] quo_r  [QuoW+1];
  logic [DetW-1:0] den_r  [QuoW+1];
  logic            neg_r  [QuoW+1];
  logic            ovf_r  [QuoW+1];
  logic            zero_r [QuoW+1];
  res_t            res_r;

  assign mag_adj = adj_i[AdjW-1] ? (~adj_i + AdjW'(1)) : adj_i;
  assign mag_det = det_i[DetW-1] ? (~det_i + DetW'(1)) : det_i;

  // prep: dividend top bits seed the remainder, overflow when quotient >= 2^33
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DetW'(mag_adj[AdjW-1:9]);
      low_r[0]  <= {mag_adj[8:0], 24'd0};
      quo_r[0]  <= '0;
      den_r[0]  <= mag_det;
      neg_r[0]  <= adj_i[AdjW-1] ^ det_i[DetW-1];
      ovf_r[0]  <= DetW'(mag_adj[AdjW-1:9]) >= mag_det;
      zero_r[0] <= (det_i == '0);
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QuoW; k++) begin : g_step
    logic [DetW:0] trial;
    logic          fit;
    assign trial = {rem_r[k-1], low_r[k-1][QuoW-1]};
    assign fit   = trial >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fit ? DetW'(trial - {1'b0, den_r[k-1]}) : DetW'(trial);
        low_r[k]  <= {low_r[k-1][QuoW-2:0], 1'b0};
        quo_r[k]  <= {quo_r[k-1][QuoW-2:0], fit};
        den_r[k]  <= den_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
    end
  end

  // apply sign, saturate, force zero when singular
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[QuoW]) begin
        res_r <= '0;
      end else if (neg_r[QuoW]) begin
        if (ovf_r[QuoW] || quo_r[QuoW] > {2'b01, {(QuoW-2){1'b0}}}) begin
          res_r <= {1'b1, {(ResW-1){1'b0}}};
        end else begin
          res_r <= ResW'(~quo_r[QuoW] + QuoW'(1));
        end
      end else if (ovf_r[QuoW] || quo_r[QuoW][QuoW-1] || quo_r[QuoW][QuoW-2]) begin
        res_r <= {1'b0, {(ResW-1){1'b1}}};
      end else begin
        res_r <= ResW'(quo_r[QuoW]);
      end
    end
  end

  assign quot_o = res_r;

endmodule

// ===== rtl/matrix_inverse_3x3.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 inverse by the adjugate: Q8.8 in, Q16.16 out, saturated, with a
// singular flag when the determinant is zero.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   in      | in_valid in_stall in_m00..m22  | to block
//   out     | out_valid out_stall out_r00..  | from block
//
// One matrix enters per cycle while in_stall is low; each result passes through
// 4 front-end stages, 33 divider bit stages, and the prep and saturation stages.
// The divider bit stages set the depth. Reset clears only the valid bits.
// A stall on a held result freezes the whole pipeline and stalls the input.
// -----------------------------------------------------------------------------
module matrix_inverse_3x3
  import mi3_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  elem_t in_m00, input elem_t in_m01, input elem_t in_m02,
  input  elem_t in_m10, input elem_t in_m11, input elem_t in_m12,
  input  elem_t in_m20, input elem_t in_m21, input elem_t in_m22,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_r00, output res_t out_r01, output res_t out_r02,
  output res_t  out_r10, output res_t out_r11, output res_t out_r12,
  output res_t  out_r20, output res_t out_r21, output res_t out_r22,
  output logic  out_singular
);

  logic  en;
  elem_t a     [9];
  adj_t  adj_s2 [9];
  elem_t row_s2 [3];
  adj_t  adj_s4 [9];
  det_t  det_s4;
  res_t  quot  [9];
  logic [TotLat-1:0] vld_r;
  logic [DivLat-1:0] sing_r;

  // advance unless a held result is stalled
  assign en       = !(vld_r[TotLat-1] && out_stall);
  assign in_stall = !en;

  assign a = '{in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20, in_m21, in_m22};

  mi3_adj u_adj (
    .clk   (clk),
    .en    (en),
    .a_i   (a),
    .adj_o (adj_s2),
    .row_o (row_s2)
  );

  mi3_det u_det (
    .clk   (clk),
    .en    (en),
    .adj_i (adj_s2),
    .row_i (row_s2),
    .adj_o (adj_s4),
    .det_o (det_s4)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk    (clk),
      .en     (en),
      .adj_i  (adj_s4[k]),
      .det_i  (det_s4),
      .quot_o (quot[k])
    );
  end

  // shift valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TotLat-2:0], in_valid};
    end
  end

  // carry the singular flag alongside the divider lanes
  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= {sing_r[DivLat-2:0], (det_s4 == '0)};
    end
  end

  assign out_valid    = vld_r[TotLat-1];
  assign out_singular = sing_r[DivLat-1];
  assign out_r00 = quot[0];
  assign out_r01 = quot[1];
  assign out_r02 = quot[2];
  assign out_r10 = quot[3];
  assign out_r11 = quot[4];
  assign out_r12 = quot[5];
  assign out_r20 = quot[6];
  assign out_r21 = quot[7];
  assign out_r22 = quot[8];

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_r00 == '0 && out_r11 == '0 && out_r22 == '0)
    else $error("singular result carries nonzero elements");
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while frozen");
`endif

endmodule
